### rtl/core/pls_pkg.sv
// Shared types and constants for the phase-lock servo.
// Used by pls_div and phase_lock_servo_core; no dependencies.
package pls_pkg;

  // History ring depth; the averaging shift assumes a power of two.
  localparam int HIST_DEPTH = 4;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SUM_W      = 16 + HIST_AW;

  localparam int DIVD_W = 32;
  localparam int DIVS_W = 20;
  localparam int DIV_CW = $clog2(DIVD_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [15:0] MIN_PERIOD    = 16'd16;
  localparam logic [8:0]  QUAL_SCALE    = 9'd400;
  localparam logic [6:0]  QUAL_FULL     = 7'd100;
  localparam logic [6:0]  SYNC_QUAL_MIN = 7'd50;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SYNC    = 2'd1,
    ACT_SET     = 2'd2,
    ACT_NOMINAL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_COLD     = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_RECOVERY = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOMINAL  = 3'd0,
    REG_DEADBAND = 3'd1,
    REG_CONV     = 3'd2,
    REG_SLEW     = 3'd3,
    REG_COLD     = 3'd4,
    REG_LOCK     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/pls_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on pls_pkg for widths and the status struct.
module pls_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pls_pkg::DIVD_W-1:0]  dividend,
  input  logic [pls_pkg::DIVS_W-1:0]  divisor,
  output logic [pls_pkg::DIVD_W-1:0]  quotient,
  output pls_pkg::div_stat_t          stat
);
  import pls_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The remainder always stays below the divisor, so 20 bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### rtl/core/phase_lock_servo_core.sv
// Phase-lock servo: sequencer, state, history ring and configuration registers.
// Depends on pls_pkg and the shared serial divider pls_div.
//
// Usage: an input transaction is either a beacon (operation 0: peer and local
// phase) or a maintenance tick (operation 1: uptime). Each one yields exactly
// one result transaction on the out_ channel. The block takes one transaction
// at a time and holds in_stall high until its result is loaded.
// A transaction goes straight from the prepare state to completion when no
// division is needed (cold sync, deadband, quality zero); when the slew or the
// quality percent is computed, the product is formed and sent to the serial divider.
// in_stall drops once the result is loaded, so a new transaction is only taken
// after the previous result has been placed in the output register.
// Results sit in an output register; if the receiver stalls, the finished
// result waits there and the next result waits for it to drain.
// Configuration writes go through cfg_valid/cfg_index/cfg_data, are always
// ready, and must only occur while the block is idle. Unknown indexes are
// ignored.
// Reset (synchronous, rst_n low) restores the register defaults, cold mode,
// the nominal period, a zero history and zero quality; no clearing pass.
module phase_lock_servo_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [15:0]                    in_peer_phase,
  input  logic [15:0]                    in_local_phase,
  input  logic [47:0]                    in_uptime,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_timer_action,
  output logic [15:0]                    out_sync_target,
  output logic [16:0]                    out_period_now,
  output logic signed [16:0]             out_phase_error,
  output logic [1:0]                     out_mode,
  output logic [6:0]                     out_quality,
  output logic                           out_is_slewing,
  output logic                           out_synchronized,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pls_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_DIVGO, S_DIVW, S_DONE
  } state_t;

  // Configuration registers.
  logic [15:0] nominal_r, deadband_r, lock_r;
  logic [19:0] conv_r;
  logic [14:0] slew_lim_r;
  logic [47:0] cold_time_r;

  // Sequencer and servo state.
  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [16:0]      period_r, period_nxt;
  logic             slew_r, slew_nxt;
  logic [6:0]       qual_r, qual_nxt;
  logic [15:0]      hist_r [HIST_DEPTH];
  logic [HIST_AW-1:0] hptr_r, hptr_nxt;
  logic             hist_we;

  // Transaction and working registers.
  logic             op_r;
  logic [15:0]      peer_r, local_r;
  logic [47:0]      uptime_r;
  logic signed [17:0] err_r, err_nxt;
  logic [15:0]      mag_r, mag_nxt;
  logic [15:0]      avg_r, avg_nxt;
  logic [DIVD_W-1:0] prod_r, prod_nxt;
  action_t          act_r, act_nxt;
  logic [15:0]      tgt_r, tgt_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  action_t          o_act_r;
  logic [15:0]      o_tgt_r;
  logic [16:0]      o_per_r;
  logic [16:0]      o_err_r;
  mode_t            o_mode_r;
  logic [6:0]       o_qual_r;
  logic             o_slew_r, o_sync_r;
  logic             out_load;

  // Arithmetic helpers.
  logic [15:0]        p_eff;
  logic [DIVS_W-1:0]  conv_eff;
  logic signed [17:0] p_s, half_s, e_raw, e_wrap;
  logic [16:0]        mag17;
  logic [15:0]        mag16;
  logic [SUM_W-1:0]   sum;
  logic [15:0]        avg;
  logic [14:0]        q_lim;
  logic [16:0]        np;
  mode_t              mode_work;

  logic               div_start;
  logic [DIVS_W-1:0]  div_den;
  logic [DIVD_W-1:0]  quo;
  div_stat_t          div_stat;

  pls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (div_den),
    .quotient (quo),
    .stat     (div_stat)
  );

  assign p_eff    = (nominal_r < MIN_PERIOD) ? MIN_PERIOD : nominal_r;
  assign conv_eff = (conv_r == '0) ? DIVS_W'(1) : conv_r;
  assign p_s      = $signed({2'b00, p_eff});
  assign half_s   = $signed({3'b000, p_eff[15:1]});
  assign e_raw    = $signed({2'b00, peer_r}) - $signed({2'b00, local_r});

  always_comb begin
    if (e_raw > half_s) begin
      e_wrap = e_raw - p_s;
    end else if (e_raw < -half_s) begin
      e_wrap = e_raw + p_s;
    end else begin
      e_wrap = e_raw;
    end
  end

  always_comb begin
    logic [17:0] neg;
    neg   = 18'(-e_wrap);
    mag17 = e_wrap[17] ? neg[16:0] : e_wrap[16:0];
    mag16 = mag17[16] ? 16'hFFFF : mag17[15:0];
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      sum = sum + SUM_W'(hist_r[i]);
    end
    avg = 16'(sum >> HIST_AW);
  end

  // Slew magnitude is clamped, then applied against the sign of the error.
  assign q_lim = (quo > DIVD_W'(slew_lim_r)) ? slew_lim_r : quo[14:0];

  always_comb begin
    if (err_r[17]) begin
      np = {1'b0, p_eff} + 17'(q_lim);
    end else if (16'(q_lim) > p_eff) begin
      np = '0;
    end else begin
      np = 17'(p_eff - 16'(q_lim));
    end
  end

  assign div_start = (state_r == S_DIVGO);
  assign div_den   = op_r ? DIVS_W'(p_eff) : conv_eff;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    period_nxt    = period_r;
    slew_nxt      = slew_r;
    qual_nxt      = qual_r;
    hptr_nxt      = hptr_r;
    hist_we       = 1'b0;
    err_nxt       = err_r;
    mag_nxt       = mag_r;
    avg_nxt       = avg_r;
    prod_nxt      = prod_r;
    act_nxt       = act_r;
    tgt_nxt       = tgt_r;
    mode_work     = mode_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        act_nxt = ACT_NONE;
        tgt_nxt = '0;
        if (!op_r) begin
          err_nxt  = e_wrap;
          mag_nxt  = mag16;
          hist_we  = 1'b1;
          hptr_nxt = (hptr_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : hptr_r + 1'b1;
          if (mode_r == MODE_COLD) begin
            tgt_nxt    = (peer_r >= p_eff) ? 16'd0 : peer_r;
            period_nxt = {1'b0, p_eff};
            slew_nxt   = 1'b0;
            act_nxt    = ACT_SYNC;
            state_nxt  = S_DONE;
          end else if (mag16 < deadband_r) begin
            if (slew_r) begin
              period_nxt = {1'b0, p_eff};
              slew_nxt   = 1'b0;
              act_nxt    = ACT_NOMINAL;
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL;
          end
        end else begin
          err_nxt = '0;
          avg_nxt = avg;
          if (mode_r == MODE_COLD && uptime_r >= cold_time_r) begin
            period_nxt = {1'b0, p_eff};
            slew_nxt   = 1'b0;
            mode_work  = MODE_LOCKED;
            act_nxt    = ACT_NOMINAL;
          end
          mode_nxt = mode_work;
          if (mode_work == MODE_LOCKED && avg > lock_r) begin
            mode_nxt = MODE_RECOVERY;
          end else if (mode_work == MODE_RECOVERY && avg < (lock_r >> 1)) begin
            mode_nxt = MODE_LOCKED;
          end
          if (avg >= (p_eff >> 2)) begin
            qual_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = op_r ? DIVD_W'(avg_r) * DIVD_W'(QUAL_SCALE)
                         : DIVD_W'(mag_r) * DIVD_W'(p_eff);
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_stat.done) begin
          if (op_r) begin
            qual_nxt = QUAL_FULL - quo[6:0];
          end else begin
            period_nxt = np;
            slew_nxt   = 1'b1;
            act_nxt    = ACT_SET;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_COLD;
      period_r    <= 17'd50000;
      slew_r      <= 1'b0;
      qual_r      <= '0;
      hptr_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      nominal_r   <= 16'd50000;
      deadband_r  <= 16'd5;
      conv_r      <= 20'd500000;
      slew_lim_r  <= 15'd250;
      cold_time_r <= 48'd10000000;
      lock_r      <= 16'd50;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      period_r    <= period_nxt;
      slew_r      <= slew_nxt;
      qual_r      <= qual_nxt;
      hptr_r      <= hptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (hist_we) begin
        hist_r[hptr_r] <= mag16;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NOMINAL:  nominal_r   <= cfg_data[15:0];
          REG_DEADBAND: deadband_r  <= cfg_data[15:0];
          REG_CONV:     conv_r      <= cfg_data[19:0];
          REG_SLEW:     slew_lim_r  <= cfg_data[14:0];
          REG_COLD:     cold_time_r <= cfg_data[47:0];
          REG_LOCK:     lock_r      <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r     <= in_operation;
      peer_r   <= in_peer_phase;
      local_r  <= in_local_phase;
      uptime_r <= in_uptime;
    end
    err_r  <= err_nxt;
    mag_r  <= mag_nxt;
    avg_r  <= avg_nxt;
    prod_r <= prod_nxt;
    act_r  <= act_nxt;
    tgt_r  <= tgt_nxt;
    if (out_load) begin
      o_act_r  <= act_r;
      o_tgt_r  <= tgt_r;
      o_per_r  <= period_r;
      o_err_r  <= err_r[16:0];
      o_mode_r <= mode_r;
      o_qual_r <= qual_r;
      o_slew_r <= slew_r;
      o_sync_r <= (mode_r == MODE_LOCKED) && (qual_r >= SYNC_QUAL_MIN);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_timer_action = o_act_r;
  assign out_sync_target  = o_tgt_r;
  assign out_period_now   = o_per_r;
  assign out_phase_error  = $signed(o_err_r);
  assign out_mode         = o_mode_r;
  assign out_quality      = o_qual_r;
  assign out_is_slewing   = o_slew_r;
  assign out_synchronized = o_sync_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIVW)
    else $error("divider finished outside the wait state");

  // A new result only appears out of the completion state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result presented without completing a transaction");

  // A hard sync is only ordered in cold mode.
  a_sync_cold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_act_r == ACT_SYNC) |-> o_mode_r == MODE_COLD)
    else $error("hard sync outside cold mode");

endmodule

### verif/phase_lock_servo_core_tb.sv
// Self-checking testbench for phase_lock_servo_core: beacons and ticks with random
// idling and stalls, checked against a behavioral servo model kept in a scoreboard.
// Depends on pls_pkg and the RTL of the phase-lock servo.
module phase_lock_servo_core_tb;
  import pls_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    action_t     act;
    logic [15:0] target;
    logic [16:0] period;
    logic [16:0] err;
    mode_t       mode;
    logic [6:0]  qual;
    logic        slewing;
    logic        synced;
  } servo_result_t;

  class servo_scoreboard;
    longint unsigned nominal, deadband, conv_span, slew_lim, cold_time, lock_thr;
    mode_t           mode;
    longint unsigned period;
    bit              slewing;
    longint unsigned history[HIST_DEPTH];
    int              hist_ptr;
    longint unsigned quality;
    servo_result_t   pending_results[$];
    int              mismatches;
    int              checked;

    function new();
      nominal = 50000;
      deadband = 5;
      conv_span = 500000;
      slew_lim = 250;
      cold_time = 10000000;
      lock_thr = 50;
      mode = MODE_COLD;
      period = 50000;
      slewing = 0;
      foreach (history[i]) history[i] = 0;
      hist_ptr = 0;
      quality = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NOMINAL:  nominal = data[15:0];
        REG_DEADBAND: deadband = data[15:0];
        REG_CONV:     conv_span = data[19:0];
        REG_SLEW:     slew_lim = data[14:0];
        REG_COLD:     cold_time = data[47:0];
        REG_LOCK:     lock_thr = data[15:0];
        default: ;
      endcase
    endfunction

    // Computes the expected result of one accepted transaction.
    function void predict_servo_step(bit op, logic [15:0] peer, logic [15:0] loc,
                                     logic [47:0] up);
      servo_result_t   r;
      longint          p, e, mag, conv, delta, lim, np;
      longint unsigned sum, avg;
      p = (nominal < 16) ? 16 : nominal;
      r.act = ACT_NONE;
      r.target = '0;
      r.err = '0;
      if (!op) begin
        e = longint'(peer) - longint'(loc);
        if (e > p / 2) e -= p;
        else if (e < -(p / 2)) e += p;
        r.err = e[16:0];
        mag = (e < 0) ? -e : e;
        history[hist_ptr] = (mag > 65535) ? 65535 : mag;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        if (mode == MODE_COLD) begin
          r.target = (longint'(peer) >= p) ? 16'd0 : peer;
          period = p;
          slewing = 0;
          r.act = ACT_SYNC;
        end else if (mag < longint'(deadband)) begin
          if (slewing) begin
            period = p;
            slewing = 0;
            r.act = ACT_NOMINAL;
          end
        end else begin
          conv = (conv_span == 0) ? 1 : conv_span;
          delta = (e * p) / conv;
          lim = slew_lim;
          if (delta > lim) delta = lim;
          else if (delta < -lim) delta = -lim;
          np = p - delta;
          if (np < 0) np = 0;
          period = np;
          slewing = 1;
          r.act = ACT_SET;
        end
      end else begin
        if (mode == MODE_COLD && longint'(up) >= cold_time) begin
          period = p;
          slewing = 0;
          mode = MODE_LOCKED;
          r.act = ACT_NOMINAL;
        end
        sum = 0;
        foreach (history[i]) sum += history[i];
        avg = sum / HIST_DEPTH;
        if (avg >= p / 4) quality = 0;
        else quality = 100 - (avg * 400) / p;
        if (mode == MODE_LOCKED) begin
          if (avg > lock_thr) mode = MODE_RECOVERY;
        end else if (mode == MODE_RECOVERY) begin
          if (avg < lock_thr / 2) mode = MODE_LOCKED;
        end
      end
      r.period = period[16:0];
      r.mode = mode;
      r.qual = quality[6:0];
      r.slewing = slewing;
      r.synced = (mode == MODE_LOCKED) && (quality >= 50);
      pending_results.push_back(r);
    endfunction

    function void report_field(string name, longint unsigned exp_v, longint unsigned act_v);
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
    endfunction

    function void check_servo_result(servo_result_t got);
      servo_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result transaction arrived with no expectation pending");
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      if (got.act !== exp_r.act) report_field("timer_action", exp_r.act, got.act);
      if (got.target !== exp_r.target) report_field("sync_target", exp_r.target, got.target);
      if (got.period !== exp_r.period) report_field("period_now", exp_r.period, got.period);
      if (got.err !== exp_r.err) report_field("phase_error", exp_r.err, got.err);
      if (got.mode !== exp_r.mode) report_field("mode", exp_r.mode, got.mode);
      if (got.qual !== exp_r.qual) report_field("quality", exp_r.qual, got.qual);
      if (got.slewing !== exp_r.slewing)
        report_field("is_slewing", exp_r.slewing, got.slewing);
      if (got.synced !== exp_r.synced)
        report_field("synchronized", exp_r.synced, got.synced);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = 1'b0;
  logic [15:0]           in_peer_phase = '0;
  logic [15:0]           in_local_phase = '0;
  logic [47:0]           in_uptime = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_timer_action;
  logic [15:0]           out_sync_target;
  logic [16:0]           out_period_now;
  logic signed [16:0]    out_phase_error;
  logic [1:0]            out_mode;
  logic [6:0]            out_quality;
  logic                  out_is_slewing;
  logic                  out_synchronized;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  servo_scoreboard sb = new();
  bit      no_idle = 1'b0;
  int      hold_requests = 0;
  int      cycles_run = 0;
  int      beacons = 0;
  int      ticks = 0;
  int      locked_results = 0;
  int      recovery_results = 0;

  phase_lock_servo_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles_run);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: checks accepted transactions and drives out_stall, including
  // one long hold-off counted here when the stimulus asks for it.
  always @(posedge clk) begin : result_side
    servo_result_t got;
    static int hold_seen = 0;
    static int hold_left = 0;
    if (rst_n && out_valid && !out_stall) begin
      got.act = action_t'(out_timer_action);
      got.target = out_sync_target;
      got.period = out_period_now;
      got.err = out_phase_error;
      got.mode = mode_t'(out_mode);
      got.qual = out_quality;
      got.slewing = out_is_slewing;
      got.synced = out_synchronized;
      if (got.mode == MODE_LOCKED) locked_results++;
      if (got.mode == MODE_RECOVERY) recovery_results++;
      sb.check_servo_result(got);
    end
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 32);
    end
  end

  task automatic send_item(bit op, logic [15:0] peer, logic [15:0] loc, logic [47:0] up);
    if (!no_idle && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_peer_phase <= peer;
    in_local_phase <= loc;
    in_uptime <= up;
    do @(posedge clk); while (in_stall);
    sb.predict_servo_step(op, peer, loc, up);
    if (op) ticks++;
    else beacons++;
  endtask

  task automatic beacon(logic [15:0] peer, logic [15:0] loc);
    send_item(1'b0, peer, loc, 48'({$urandom, $urandom}));
  endtask

  task automatic tick(logic [47:0] up);
    send_item(1'b1, 16'($urandom), 16'($urandom), up);
  endtask

  // Pauses the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [15:0] peer, loc;
    int          spread;
    repeat (count) begin
      if ($urandom_range(99) < 25) begin
        tick(48'({$urandom, $urandom}));
      end else begin
        peer = 16'($urandom);
        if ($urandom_range(1)) begin
          spread = int'(sb.deadband > 200 ? 200 : sb.deadband) * 2 + 40;
          loc = peer + 16'($urandom_range(2 * spread) - spread);
        end else begin
          loc = 16'($urandom);
        end
        beacon(peer, loc);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cold mode: hard syncs, including peer phases at and past the period.
    beacon(16'd0, 16'd0);
    beacon(16'hFFFF, 16'd0);
    beacon(16'd49999, 16'hFFFF);
    beacon(16'd50000, 16'd12345);
    tick(48'd0);
    drain();
    write_reg(REG_COLD, 48'hFFFF_FFFF_FFFF);
    tick(48'hFFFF_FFFF_FFFE);
    // Cold mode ends here and the lock check runs on the same tick.
    tick(48'hFFFF_FFFF_FFFF);
    beacon(16'd1000, 16'd1000);
    beacon(16'd1100, 16'd1000);
    beacon(16'd1002, 16'd1000);
    beacon(16'd900, 16'd1000);
    tick(48'd5);
    drain();
    write_reg(REG_DEADBAND, 48'd0);
    write_reg(REG_NOMINAL, 48'd0);
    write_reg(REG_CONV, 48'd0);
    write_reg(REG_SLEW, 48'd32767);
    write_reg(REG_UNUSED, 48'd1234);
    beacon(16'd7, 16'd7);
    beacon(16'd8, 16'd0);
    beacon(16'hFFFF, 16'd0);
    beacon(16'd0, 16'hFFFF);
    tick(48'd1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_NOMINAL, 48'd16);
          write_reg(REG_DEADBAND, 48'd0);
          write_reg(REG_CONV, 48'd1);
          write_reg(REG_LOCK, 48'd0);
        end
        1: begin
          write_reg(REG_NOMINAL, 48'd65535);
          write_reg(REG_DEADBAND, 48'd65535);
          write_reg(REG_CONV, 48'hFFFFF);
          write_reg(REG_SLEW, 48'd0);
          write_reg(REG_LOCK, 48'd65535);
          write_reg(REG_COLD, 48'd0);
        end
        default: begin
          write_reg(REG_NOMINAL, 48'($urandom_range(16, 65535)));
          write_reg(REG_DEADBAND, 48'($urandom_range(0, 300)));
          write_reg(REG_CONV, 48'($urandom_range(1, 4000)));
          write_reg(REG_SLEW, 48'($urandom_range(0, 32767)));
          write_reg(REG_LOCK, 48'($urandom_range(0, 400)));
          write_reg(REG_COLD, 48'({$urandom, $urandom}));
        end
      endcase
      if (phase == 3) hold_requests++;
      no_idle = (phase == 5);
      send_random(135);
      drain();
    end
    no_idle = 1'b0;

    repeat (60) @(posedge clk);
    $display("Covered %0d beacons and %0d ticks, %0d results checked", beacons, ticks,
             sb.checked);
    $display("Results in locked mode: %0d, in recovery mode: %0d", locked_results,
             recovery_results);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/pls_pkg.sv
rtl/core/pls_div.sv
rtl/core/phase_lock_servo_core.sv
verif/phase_lock_servo_core_tb.sv
